// ----- rtl/jlvr_pkg.sv -----
// Shared types, constants and helper functions for the jerk-limited velocity ramp.
package jlvr_pkg;

    // Field widths
    localparam int LIM_W     = 31;
    localparam int RATE_W    = 32;
    localparam int POS_W     = 48;
    localparam int STEP_W    = 18;

    // Working widths inside the datapath
    localparam int WIDE_W    = RATE_W + 2;
    localparam int PSUM_W    = POS_W + 1;
    localparam int PROD_W    = 2 * LIM_W;
    localparam int TERM_W    = 30;
    localparam int BRK_W     = 64;
    localparam int CMP_W     = BRK_W + 1;
    localparam int DIV_N_W   = 2 * LIM_W + 1;
    localparam int DIV_D_W   = LIM_W + 1;

    // Time step in units of 2^-20 s
    localparam int                DT_SHIFT = 20;
    localparam logic [STEP_W-1:0] DT_MIN   = 18'd105;
    localparam logic [STEP_W-1:0] DT_MAX   = 18'd209715;

    // Limit registers and their reset values
    localparam int               CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_VLIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JLIM = 2'd2;
    localparam logic [LIM_W-1:0] VLIM_RST  = 31'd6553600;
    localparam logic [LIM_W-1:0] ALIM_RST  = 31'd13107200;
    localparam logic [LIM_W-1:0] JLIM_RST  = 31'd65536000;

    typedef struct packed {
        logic signed [RATE_W-1:0] target_rate;
        logic        [STEP_W-1:0] step_time;
    } jlvr_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  new_position;
        logic signed [RATE_W-1:0] new_velocity;
        logic signed [RATE_W-1:0] new_accel;
        logic signed [RATE_W-1:0] new_jerk;
    } jlvr_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PICK,
        ST_ACC,
        ST_AMUL,
        ST_VSUM,
        ST_SNAP,
        ST_PMUL,
        ST_POS,
        ST_OUT
    } jlvr_state_t;

    // Clamp a sign-extended value to the symmetric range given by a limit.
    function automatic logic signed [RATE_W-1:0] clamp_lim(
        input logic signed [WIDE_W-1:0] x,
        input logic        [LIM_W-1:0]  lim
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] r;
        hi = signed'(WIDE_W'(lim));
        lo = -hi;
        if (x > hi) begin
            r = hi;
        end else if (x < lo) begin
            r = lo;
        end else begin
            r = x;
        end
        return r[RATE_W-1:0];
    endfunction

    // Magnitude of a value that is known to lie within a limit's range.
    function automatic logic [LIM_W-1:0] mag_lim(input logic signed [RATE_W-1:0] x);
        logic signed [RATE_W-1:0] n;
        n = -x;
        return x[RATE_W-1] ? n[LIM_W-1:0] : x[LIM_W-1:0];
    endfunction

    // Scale a product by 2^-20, rounding half up on the magnitude.
    function automatic logic [TERM_W-1:0] dt_round(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = {1'b0, p} + ((PROD_W + 1)'(1) << (DT_SHIFT - 1));
        return s[DT_SHIFT +: TERM_W];
    endfunction

endpackage

// ----- rtl/jlvr_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module jlvr_div import jlvr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] dvs_reg, dvs_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W+1:0] diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_N_W-1]};
        diff      = {1'b0, trial} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_N_W);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so a successful
            // subtraction always fits back into the remainder register.
            if (!diff[DIV_D_W+1]) begin
                rem_next = diff[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && cnt_reg == CNT_W'(DIV_N_W))
        else $error("divider did not start");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider flagged done while still busy");

    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with an empty bit count");

endmodule

// ----- rtl/jerk_limited_velocity_ramp_core.sv -----
// Top level of the jerk-limited velocity ramp: sequencer, shared multiplier and axis state.
//
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   jlvr_in_t  (target_rate, step_time)
//  m_       out        m_valid / m_ready   jlvr_out_t (new_position .. new_jerk)
//  cfg_     in         cfg_we              cfg_idx, cfg_wdata (limit registers)
//
// An item that holds goes from setup straight to output, a settled item skips the divider,
// and a full ramp step waits on the bit-serial divider for the braking velocity.
// Every product goes through the one registered 31 x 31 multiplier in turn.
// Reset is synchronous and clears the axis state and restores the default limits.
// s_ready is high only while the sequencer is idle; a finished item waits in the
// output register, and the next item is taken while it waits for m_ready.
module jerk_limited_velocity_ramp_core import jlvr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  jlvr_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output jlvr_out_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [LIM_W-1:0]     cfg_wdata
);

    jlvr_state_t state_reg, state_next;

    logic [LIM_W-1:0] vlim_reg, vlim_next;
    logic [LIM_W-1:0] alim_reg, alim_next;
    logic [LIM_W-1:0] jlim_reg, jlim_next;

    logic signed [POS_W-1:0]  position_reg, position_next;
    logic signed [RATE_W-1:0] velocity_reg, velocity_next;
    logic signed [RATE_W-1:0] accel_reg, accel_next;
    logic signed [RATE_W-1:0] jerk_reg, jerk_next;

    logic signed [RATE_W-1:0] tgt_reg, tgt_next;
    logic        [STEP_W-1:0] step_reg, step_next;
    logic        [STEP_W-1:0] dt_reg, dt_next;
    logic signed [RATE_W-1:0] vt_reg, vt_next;
    logic signed [RATE_W-1:0] vc_reg, vc_next;
    logic signed [RATE_W-1:0] ac_reg, ac_next;
    logic signed [RATE_W:0]   verr_reg, verr_next;
    logic signed [BRK_W-1:0]  vb_reg, vb_next;
    logic signed [RATE_W-1:0] jk_reg, jk_next;
    logic signed [RATE_W-1:0] an_reg, an_next;
    logic signed [RATE_W:0]   vsum_reg, vsum_next;
    logic signed [RATE_W-1:0] vn_reg, vn_next;
    logic        [PROD_W-1:0] prod_reg, prod_next;

    jlvr_out_t out_reg, out_next;
    logic      m_valid_reg, m_valid_next;

    logic [LIM_W-1:0]   mul_a;
    logic [LIM_W-1:0]   mul_b;
    logic               div_start;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quo;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;

    logic                     hold;
    logic                     settled;
    logic                     out_free;
    logic signed [RATE_W:0]   verr_now;
    logic [TERM_W-1:0]        term;
    logic signed [WIDE_W-1:0] term_s;
    logic signed [WIDE_W-1:0] sterm;
    logic signed [WIDE_W-1:0] amax_m1;
    logic signed [RATE_W-1:0] jmax_s;
    logic signed [CMP_W-1:0]  brk_diff;
    logic signed [BRK_W-1:0]  brk_mag;
    logic signed [WIDE_W-1:0] d2;
    logic                     snap;
    logic signed [RATE_W-1:0] vn_val;
    logic signed [PSUM_W-1:0] psum;

    jlvr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Conditions shared by the sequencer and the datapath.
    assign hold     = (step_reg == '0) || (vlim_reg == '0) || (alim_reg == '0)
                      || (jlim_reg == '0);
    assign verr_now = (RATE_W + 1)'(vt_reg) - (RATE_W + 1)'(vc_reg);
    assign settled  = (verr_now >= -1) && (verr_now <= 1) && (ac_reg >= -1) && (ac_reg <= 1);
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_SETUP;
            ST_SETUP:    state_next = hold ? ST_OUT : ST_CHECK;
            ST_CHECK:    state_next = settled ? ST_PMUL : ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_done) state_next = ST_PICK;
            ST_PICK:     state_next = ST_ACC;
            ST_ACC:      state_next = ST_AMUL;
            ST_AMUL:     state_next = ST_VSUM;
            ST_VSUM:     state_next = ST_SNAP;
            ST_SNAP:     state_next = ST_PMUL;
            ST_PMUL:     state_next = ST_POS;
            ST_POS:      state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, divider start and multiplier operands.
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_CHECK: begin
                mul_a = mag_lim(ac_reg);
                mul_b = mag_lim(ac_reg);
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
            end
            ST_PICK: begin
                mul_a = jlim_reg;
                mul_b = LIM_W'(dt_reg);
            end
            ST_AMUL: begin
                mul_a = mag_lim(an_reg);
                mul_b = LIM_W'(dt_reg);
            end
            ST_PMUL: begin
                mul_a = mag_lim(vn_reg);
                mul_b = LIM_W'(dt_reg);
            end
            default: begin
            end
        endcase
    end

    // Braking velocity: (|a|^2 + j) / (2j), rounded half up.
    assign div_dividend = {1'b0, prod_reg} + DIV_N_W'(jlim_reg);
    assign div_divisor  = {jlim_reg, 1'b0};

    // Datapath
    always_comb begin
        vlim_next     = vlim_reg;
        alim_next     = alim_reg;
        jlim_next     = jlim_reg;
        position_next = position_reg;
        velocity_next = velocity_reg;
        accel_next    = accel_reg;
        jerk_next     = jerk_reg;
        tgt_next      = tgt_reg;
        step_next     = step_reg;
        dt_next       = dt_reg;
        vt_next       = vt_reg;
        vc_next       = vc_reg;
        ac_next       = ac_reg;
        verr_next     = verr_reg;
        vb_next       = vb_reg;
        jk_next       = jk_reg;
        an_next       = an_reg;
        vsum_next     = vsum_reg;
        vn_next       = vn_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

        term     = dt_round(prod_reg);
        term_s   = signed'(WIDE_W'(term));
        sterm    = '0;
        amax_m1  = signed'(WIDE_W'(alim_reg)) - 1;
        jmax_s   = signed'(RATE_W'(jlim_reg));
        brk_mag  = signed'(BRK_W'(div_quo));
        brk_diff = CMP_W'(verr_reg) - CMP_W'(vb_reg);
        d2       = WIDE_W'(vt_reg) - WIDE_W'(vsum_reg);
        snap     = (verr_reg == 0) || (d2 == 0) || ((verr_reg < 0) != (d2 < 0));
        vn_val   = snap ? vt_reg : clamp_lim(WIDE_W'(vsum_reg), vlim_reg);
        psum     = '0;

        if (cfg_we) begin
            unique case (cfg_idx)
                REG_VLIM: vlim_next = cfg_wdata;
                REG_ALIM: alim_next = cfg_wdata;
                REG_JLIM: jlim_next = cfg_wdata;
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    tgt_next  = s_data.target_rate;
                    step_next = s_data.step_time;
                end
            end
            ST_SETUP: begin
                if (step_reg < DT_MIN) begin
                    dt_next = DT_MIN;
                end else if (step_reg > DT_MAX) begin
                    dt_next = DT_MAX;
                end else begin
                    dt_next = step_reg;
                end
                vt_next = clamp_lim(WIDE_W'(tgt_reg), vlim_reg);
                vc_next = clamp_lim(WIDE_W'(velocity_reg), vlim_reg);
                ac_next = clamp_lim(WIDE_W'(accel_reg), alim_reg);
            end
            ST_CHECK: begin
                verr_next = verr_now;
                if (settled) begin
                    velocity_next = vt_reg;
                    accel_next    = '0;
                    jerk_next     = '0;
                    vn_next       = vt_reg;
                end
            end
            ST_DIV_WAIT: begin
                vb_next = (ac_reg < 0) ? -brk_mag : brk_mag;
            end
            ST_PICK: begin
                if (brk_diff > 1) begin
                    jk_next = (WIDE_W'(ac_reg) < amax_m1) ? jmax_s : '0;
                end else if (brk_diff < -1) begin
                    jk_next = (WIDE_W'(ac_reg) > -amax_m1) ? -jmax_s : '0;
                end else if (ac_reg > 1) begin
                    jk_next = -jmax_s;
                end else if (ac_reg < -1) begin
                    jk_next = jmax_s;
                end else begin
                    jk_next = '0;
                end
            end
            ST_ACC: begin
                if (jk_reg > 0) begin
                    sterm = term_s;
                end else if (jk_reg < 0) begin
                    sterm = -term_s;
                end
                an_next = clamp_lim(WIDE_W'(ac_reg) + sterm, alim_reg);
            end
            ST_VSUM: begin
                sterm     = (an_reg < 0) ? -term_s : term_s;
                vsum_next = (RATE_W + 1)'(WIDE_W'(vc_reg) + sterm);
            end
            ST_SNAP: begin
                // Reaching or crossing the target ends the ramp on the target.
                velocity_next = vn_val;
                vn_next       = vn_val;
                accel_next    = snap ? '0 : an_reg;
                jerk_next     = snap ? '0 : jk_reg;
            end
            ST_POS: begin
                sterm = (vn_reg < 0) ? -term_s : term_s;
                psum  = PSUM_W'(position_reg) + PSUM_W'(sterm);
                if (psum[PSUM_W-1] != psum[PSUM_W-2]) begin
                    position_next = psum[PSUM_W-1] ? {1'b1, {(POS_W - 1){1'b0}}}
                                                   : {1'b0, {(POS_W - 1){1'b1}}};
                end else begin
                    position_next = psum[POS_W-1:0];
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_next.new_position = position_reg;
                    out_next.new_velocity = velocity_reg;
                    out_next.new_accel    = accel_reg;
                    out_next.new_jerk     = jerk_reg;
                    m_valid_next          = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            vlim_reg     <= VLIM_RST;
            alim_reg     <= ALIM_RST;
            jlim_reg     <= JLIM_RST;
            position_reg <= '0;
            velocity_reg <= '0;
            accel_reg    <= '0;
            jerk_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            vlim_reg     <= vlim_next;
            alim_reg     <= alim_next;
            jlim_reg     <= jlim_next;
            position_reg <= position_next;
            velocity_reg <= velocity_next;
            accel_reg    <= accel_next;
            jerk_reg     <= jerk_next;
        end
    end

    always_ff @(posedge aclk) begin
        tgt_reg  <= tgt_next;
        step_reg <= step_next;
        dt_reg   <= dt_next;
        vt_reg   <= vt_next;
        vc_reg   <= vc_next;
        ac_reg   <= ac_next;
        verr_reg <= verr_next;
        vb_reg   <= vb_next;
        jk_reg   <= jk_next;
        an_reg   <= an_next;
        vsum_reg <= vsum_next;
        vn_reg   <= vn_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_accept_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SETUP)
        else $error("accepted item did not start the sequence");

    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SETUP && hold |=> $stable(position_reg) && $stable(velocity_reg)
            && $stable(accel_reg) && $stable(jerk_reg))
        else $error("held step changed the axis state");

    a_settle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK && settled |=> accel_reg == 0 && jerk_reg == 0)
        else $error("settled step left acceleration or jerk");

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT && out_free |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("finished item was not presented");

endmodule

// ----- dv/jlvr_ramp_checker.sv -----
// Checker for the velocity ramp: follows both channels and the limit writes, predicts, compares.
`timescale 1ns / 1ps

module jlvr_ramp_checker import jlvr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  jlvr_in_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  jlvr_out_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [LIM_W-1:0]     cfg_wdata,
    output int                   fail_count,
    output int                   pending
);

    typedef longint unsigned u64_t;

    localparam longint POS_HI = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint POS_LO = -(longint'(1) <<< (POS_W - 1));

    // Predicted axis state and the limits as last written.
    logic signed [POS_W-1:0]  pos_q;
    logic signed [RATE_W-1:0] vel_q;
    logic signed [RATE_W-1:0] acc_q;
    logic signed [RATE_W-1:0] jerk_q;
    logic        [LIM_W-1:0]  vlim_q;
    logic        [LIM_W-1:0]  alim_q;
    logic        [LIM_W-1:0]  jlim_q;

    jlvr_out_t expected_states_q[$];
    int        mismatches = 0;
    int        queued = 0;

    assign fail_count = mismatches;
    assign pending    = queued;

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic longint bound(input longint x, input longint lo, input longint hi);
        if (x < lo) begin
            return lo;
        end
        if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

    // x * dt / 2^20, rounded to nearest with ties away from zero.
    function automatic longint times_dt(input longint x, input u64_t dt);
        u64_t mag;
        u64_t r;
        mag = (x < 0) ? u64_t'(-x) : u64_t'(x);
        r = (mag * dt + (u64_t'(1) << (DT_SHIFT - 1))) >> DT_SHIFT;
        return (x < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic jlvr_out_t step_axis(input jlvr_in_t item);
        longint vmax, amax, jmax, vt, vc, ac, verr, vbrake, jrk, anext, vnext, d1, d2, ppos;
        u64_t   dt, amag, bmag;
        vmax = longint'(vlim_q);
        amax = longint'(alim_q);
        jmax = longint'(jlim_q);
        if (item.step_time == '0 || vmax == 0 || amax == 0 || jmax == 0) begin
            return '{new_position: pos_q, new_velocity: vel_q, new_accel: acc_q,
                     new_jerk: jerk_q};
        end
        dt = item.step_time;
        if (dt < DT_MIN) begin
            dt = DT_MIN;
        end else if (dt > DT_MAX) begin
            dt = DT_MAX;
        end
        vt   = bound(longint'($signed(item.target_rate)), -vmax, vmax);
        vc   = bound(longint'(vel_q), -vmax, vmax);
        ac   = bound(longint'(acc_q), -amax, amax);
        verr = vt - vc;
        if (verr >= -1 && verr <= 1 && ac >= -1 && ac <= 1) begin
            // Already at the target: hold it and coast.
            vnext = vt;
            anext = 0;
            jrk   = 0;
        end else begin
            amag   = (ac < 0) ? u64_t'(-ac) : u64_t'(ac);
            bmag   = (amag * amag + u64_t'(jmax)) / (u64_t'(2) * u64_t'(jmax));
            vbrake = (ac < 0) ? -longint'(bmag) : longint'(bmag);
            if (verr > vbrake + 1) begin
                jrk = (ac < amax - 1) ? jmax : 0;
            end else if (verr < vbrake - 1) begin
                jrk = (ac > -amax + 1) ? -jmax : 0;
            end else if (ac > 1) begin
                jrk = -jmax;
            end else if (ac < -1) begin
                jrk = jmax;
            end else begin
                jrk = 0;
            end
            anext = bound(ac + times_dt(jrk, dt), -amax, amax);
            vnext = vc + times_dt(anext, dt);
            d1 = vt - vc;
            d2 = vt - vnext;
            // Reaching or passing the target snaps onto it.
            if (d1 == 0 || d2 == 0 || ((d1 < 0) != (d2 < 0))) begin
                vnext = vt;
                anext = 0;
                jrk   = 0;
            end else begin
                vnext = bound(vnext, -vmax, vmax);
            end
        end
        ppos   = bound(longint'(pos_q) + times_dt(vnext, dt), POS_LO, POS_HI);
        pos_q  = ppos[POS_W-1:0];
        vel_q  = vnext[RATE_W-1:0];
        acc_q  = anext[RATE_W-1:0];
        jerk_q = jrk[RATE_W-1:0];
        return '{new_position: pos_q, new_velocity: vel_q, new_accel: acc_q, new_jerk: jerk_q};
    endfunction

    always @(posedge aclk) begin
        jlvr_out_t want;
        if (!aresetn) begin
            pos_q  = '0;
            vel_q  = '0;
            acc_q  = '0;
            jerk_q = '0;
            vlim_q = VLIM_RST;
            alim_q = ALIM_RST;
            jlim_q = JLIM_RST;
            expected_states_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_states_q.size() == 0) begin
                    note_mismatch("result with no item outstanding");
                end else begin
                    want = expected_states_q.pop_front();
                    if (m_data.new_position !== want.new_position) begin
                        note_mismatch($sformatf("new_position got %0d want %0d",
                                                m_data.new_position, want.new_position));
                    end
                    if (m_data.new_velocity !== want.new_velocity) begin
                        note_mismatch($sformatf("new_velocity got %0d want %0d",
                                                m_data.new_velocity, want.new_velocity));
                    end
                    if (m_data.new_accel !== want.new_accel) begin
                        note_mismatch($sformatf("new_accel got %0d want %0d",
                                                m_data.new_accel, want.new_accel));
                    end
                    if (m_data.new_jerk !== want.new_jerk) begin
                        note_mismatch($sformatf("new_jerk got %0d want %0d",
                                                m_data.new_jerk, want.new_jerk));
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_idx)
                    REG_VLIM: vlim_q = cfg_wdata;
                    REG_ALIM: alim_q = cfg_wdata;
                    REG_JLIM: jlim_q = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_states_q.push_back(step_axis(s_data));
            end
        end
        queued = expected_states_q.size();
    end

endmodule

// ----- dv/tb_jerk_limited_velocity_ramp_core.sv -----
// Testbench top for the velocity ramp core: clock, reset, stimulus, limit writes and verdict.
`timescale 1ns / 1ps

module tb_jerk_limited_velocity_ramp_core;
    import jlvr_pkg::*;

    typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

    localparam logic [CFG_IDX_W-1:0]   REG_SPARE    = 2'd3;
    localparam logic signed [RATE_W-1:0] RATE_TOP   = 32'sh7FFF_FFFF;
    localparam logic signed [RATE_W-1:0] RATE_BOTTOM = 32'sh8000_0000;
    localparam logic [STEP_W-1:0]      STEP_TOP     = '1;
    localparam logic [LIM_W-1:0]       LIM_TOP      = '1;
    localparam int                     DRAIN_CYCLES = 100;
    localparam int                     BURST_ITEMS  = 110;
    // A short run at full speed before backing off again.
    localparam int                     SOAK_ITEMS   = 20;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    jlvr_in_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b1;
    jlvr_out_t            m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [LIM_W-1:0]     cfg_wdata = '0;

    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    logic [LIM_W-1:0] vlim_now       = VLIM_RST;
    int               fail_count;
    int               pending;

    jerk_limited_velocity_ramp_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    jlvr_ramp_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #200_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_FULL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PACE_SEND_GAPS: begin
                send_idle_pct  = 52;
                recv_stall_pct = 0;
            end
            PACE_RECV_STALLS: begin
                send_idle_pct  = 0;
                recv_stall_pct = 52;
            end
            default: begin
                send_idle_pct  = 22;
                recv_stall_pct = 22;
            end
        endcase
    endtask

    // Offers one item, possibly after an idle gap, and returns at the edge that takes it.
    task automatic send_item(input logic signed [RATE_W-1:0] rate, input logic [STEP_W-1:0] dt);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 120) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{target_rate: rate, step_time: dt};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(input logic [LIM_W-1:0] v, input logic [LIM_W-1:0] a,
                              input logic [LIM_W-1:0] j);
        write_reg(REG_VLIM, v);
        write_reg(REG_ALIM, a);
        write_reg(REG_JLIM, j);
        end_writes();
        vlim_now = v;
    endtask

    // Waits until every result is back and the core has had time to go idle.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        cfg_we  <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic random_limits();
        logic [LIM_W-1:0] v, a, j;
        case ($urandom_range(3))
            0: begin
                v = VLIM_RST;
                a = ALIM_RST;
                j = JLIM_RST;
            end
            1: begin
                v = LIM_W'($urandom_range(1, 1 << 24));
                a = LIM_W'($urandom_range(1, 1 << 26));
                j = LIM_W'($urandom_range(1, 1 << 28));
            end
            2: begin
                v = LIM_W'($urandom);
                a = LIM_W'($urandom);
                j = LIM_W'($urandom);
                if (v == '0) v = LIM_W'(1);
                if (a == '0) a = LIM_W'(1);
                if (j == '0) j = LIM_W'(1);
            end
            default: begin
                v = LIM_W'($urandom_range(1, 64));
                a = LIM_W'($urandom_range(1, 64));
                j = LIM_W'($urandom_range(1, 64));
            end
        endcase
        set_limits(v, a, j);
    endtask

    // Targets are held for runs of items so that ramps can reach, snap to and settle
    // on them; now and then a target is wild or nudged by up to one unit.
    task automatic random_burst(input int n_items);
        longint                   span, tgt;
        int                       moving, run_left;
        logic signed [RATE_W-1:0] rate;
        logic [STEP_W-1:0]        dt;
        moving   = 0;
        run_left = 0;
        rate     = '0;
        while (moving < n_items) begin
            if (run_left == 0) begin
                case ($urandom_range(9))
                    0: rate = RATE_W'($urandom);
                    1: rate = '0;
                    2: rate = $urandom_range(1) ? RATE_TOP : RATE_BOTTOM;
                    3: rate = rate + $urandom_range(2) - 1;
                    default: begin
                        span = longint'(vlim_now) + longint'(vlim_now) / 4 + 1;
                        tgt  = longint'({$urandom, $urandom} % $unsigned(2 * span + 1)) - span;
                        if (tgt > longint'(RATE_TOP)) tgt = longint'(RATE_TOP);
                        if (tgt < longint'(RATE_BOTTOM)) tgt = longint'(RATE_BOTTOM);
                        rate = tgt[RATE_W-1:0];
                    end
                endcase
                run_left = $urandom_range(1, 40);
            end
            case ($urandom_range(19))
                0, 1:    dt = '0;
                2, 3:    dt = STEP_W'($urandom_range(1, 300));
                4, 5, 6: dt = STEP_W'($urandom);
                default: dt = STEP_W'($urandom_range(300, 60000));
            endcase
            send_item(rate, dt);
            run_left--;
            if (dt != '0) moving++;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed items at the reset limits: settling from rest, a zero step,
        // both ends of the step clamp and targets beyond the velocity limit.
        set_pace(PACE_FULL);
        send_item('0, 18'd1000);
        send_item('0, '0);
        send_item(RATE_TOP, 18'd1);
        send_item(RATE_TOP, STEP_TOP);
        repeat (3) send_item(RATE_BOTTOM, 18'd100000);
        send_item(-32'sd1, 18'd209715);
        send_item(32'sd6553600, 18'd209716);
        drain();

        // A zero in any one limit freezes the axis.
        set_limits('0, ALIM_RST, JLIM_RST);
        send_item(32'sd65536, 18'd1000);
        drain();
        set_limits(VLIM_RST, '0, JLIM_RST);
        send_item(32'sd65536, 18'd1000);
        drain();
        set_limits(VLIM_RST, ALIM_RST, '0);
        send_item(32'sd65536, 18'd1000);
        drain();

        // A write to the unused index must leave the limits alone.
        set_limits(VLIM_RST, ALIM_RST, JLIM_RST);
        write_reg(REG_SPARE, LIM_TOP);
        end_writes();
        repeat (2) send_item(32'sd6553600, 18'd50000);
        drain();

        set_limits(LIM_TOP, LIM_TOP, LIM_TOP);
        repeat (2) send_item(RATE_TOP, STEP_TOP);
        repeat (2) send_item(RATE_BOTTOM, STEP_TOP);
        drain();
        set_limits(31'd1, 31'd1, 31'd1);
        send_item(32'sd5, 18'd1000);
        send_item(-32'sd3, 18'd50000);
        send_item(32'sd1, 18'd2000);
        send_item('0, 18'd2000);
        drain();

        for (int p = 0; p < 4; p++) begin
            set_pace(pace_t'(p));
            repeat (2) begin
                random_limits();
                random_burst(BURST_ITEMS);
                drain();
            end
        end

        // Run flat out at the top speed for a while, then back off.
        set_pace(PACE_FULL);
        set_limits(LIM_TOP, LIM_TOP, LIM_TOP);
        repeat (SOAK_ITEMS) send_item(RATE_TOP, STEP_TOP);
        repeat (20) send_item(RATE_BOTTOM, STEP_TOP);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
